// ===== design/cpct_pkg.sv =====
// Package for the collider pair contact tracker: widths, codes, shared types.
// No dependencies.
package cpct_pkg;

  localparam int MaxCollidersDef = 64;
  localparam int IdW   = 6;
  localparam int PosW  = 24;
  localparam int SizeW = 16;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } event_t;

  typedef struct packed {
    logic [IdW-1:0]          left_id;
    logic [IdW-1:0]          right_id;
    logic                    left_kind;
    logic                    right_kind;
    logic signed [PosW-1:0]  left_x;
    logic signed [PosW-1:0]  left_y;
    logic signed [PosW-1:0]  right_x;
    logic signed [PosW-1:0]  right_y;
    logic [SizeW-1:0]        left_w;
    logic [SizeW-1:0]        left_h;
    logic [SizeW-1:0]        right_w;
    logic [SizeW-1:0]        right_h;
  } item_t;

  typedef struct packed {
    logic [1:0] contact_event;
    logic       overlapping;
  } result_t;

endpackage

// ===== design/cpct_if.sv =====
// Valid/ready channel interfaces for the tracker's input and result streams.
// Depends on cpct_pkg.
interface cpct_in_if;
  logic            valid;
  logic            ready;
  cpct_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpct_out_if;
  logic              valid;
  logic              ready;
  cpct_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cpct_front.sv =====
// Front part: accepts pairs, runs the overlap tests over three stages, and
// pushes (key, valid pair, hit) into a short queue. Depends on cpct_pkg.
module cpct_front #(
  parameter int MAX_COLLIDERS = cpct_pkg::MaxCollidersDef,
  parameter int KeyW = 2 * cpct_pkg::IdW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cpct_pkg::item_t  in_item,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [KeyW-1:0]  q_key,
  output logic             q_pair,
  output logic             q_hit
);
  // 1/512 pixel units: positions doubled, sizes times 100 per half
  localparam int CW = 28;  // coordinate width
  localparam int SW = 56;  // square width

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            pair;
    logic            rr;
    logic            cc;
    logic signed [CW-1:0] dx, dy, ddx, ddy, dx2, dy2, rad, hw, dbx, dby;
  } s1_t;

  logic       s1_v_r, s2_v_r, s3_v_r;
  s1_t        s1_r, s1_nxt;

  // 2-entry queue
  logic [KeyW+1:0] qm_r [cpct_pkg::QDepth];
  logic [1:0]      cnt_r;
  logic            wp_r, rp_r;

  // stall the whole pipe only when the queue is full and not draining
  logic stall;
  assign stall = s3_v_r && (cnt_r == 2'd2) && !q_ready;
  assign in_ready = !stall;

  function automatic logic signed [CW-1:0] px(input logic signed [cpct_pkg::PosW-1:0] p);
    return CW'(p) <<< 1;
  endfunction
  function automatic logic signed [CW-1:0] sz(input logic [cpct_pkg::SizeW-1:0] s);
    return CW'({1'b0, s}) * CW'(100);
  endfunction

  always_comb begin
    logic signed [CW-1:0] lx, ly, rx, ry, lw, lh, rw, rh, bx, by, cx, cy, r, bw, bh;
    lx = px(in_item.left_x);  ly = px(in_item.left_y);
    rx = px(in_item.right_x); ry = px(in_item.right_y);
    lw = sz(in_item.left_w);  lh = sz(in_item.left_h);
    rw = sz(in_item.right_w); rh = sz(in_item.right_h);
    s1_nxt.key  = {in_item.left_id, in_item.right_id};
    s1_nxt.pair = (in_item.left_id != in_item.right_id) &&
                  (32'(in_item.left_id) < MAX_COLLIDERS) &&
                  (32'(in_item.right_id) < MAX_COLLIDERS);
    s1_nxt.rr = !in_item.left_kind && !in_item.right_kind;
    s1_nxt.cc = in_item.left_kind && in_item.right_kind;
    if (!in_item.left_kind) begin
      bx = lx; by = ly; bw = lw <<< 1; bh = lh <<< 1;
      cx = rx + rw; cy = ry + rh; r = rw;
    end else begin
      bx = rx; by = ry; bw = rw <<< 1; bh = rh <<< 1;
      cx = lx + lw; cy = ly + lh; r = lw;
    end
    if (s1_nxt.rr) begin
      s1_nxt.dx = lx - rx; s1_nxt.dy = ly - ry; s1_nxt.rad = lw + rw;
      s1_nxt.hw = lh + rh;
    end else if (s1_nxt.cc) begin
      s1_nxt.dx = (lx + lw) - (rx + rw); s1_nxt.dy = (ly + lh) - (ry + rh);
      s1_nxt.rad = lw + rw; s1_nxt.hw = '0;
    end else begin
      s1_nxt.dx = cx - bx; s1_nxt.dy = cy - by; s1_nxt.rad = r; s1_nxt.hw = bw;
    end
    s1_nxt.ddx = cx - (bx + bw);
    s1_nxt.ddy = cy - (by + bh);
    s1_nxt.dbx = bx + bw + r;
    s1_nxt.dby = by + bh + r;
    s1_nxt.dx2 = cx;
    s1_nxt.dy2 = cy;
  end

  // stage 2: squares and box compares
  logic [SW-1:0] sq_dx_r, sq_dy_r, sq_ddx_r, sq_ddy_r, sq_r_r;
  logic [KeyW-1:0] s2_key_r;
  logic s2_pair_r, s2_rr_r, s2_cc_r, s2_rrhit_r, s2_box_r;

  function automatic logic [SW-1:0] sq(input logic signed [CW-1:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    return e * e;
  endfunction

  // stage 3: sums and final compare
  logic [KeyW-1:0] s3_key_r;
  logic s3_pair_r, s3_hit_r;
  logic [SW:0] d00, d01, d10, d11;
  logic hit3;
  assign d00 = {1'b0, sq_dx_r} + {1'b0, sq_dy_r};
  assign d01 = {1'b0, sq_dx_r} + {1'b0, sq_ddy_r};
  assign d10 = {1'b0, sq_ddx_r} + {1'b0, sq_dy_r};
  assign d11 = {1'b0, sq_ddx_r} + {1'b0, sq_ddy_r};
  always_comb begin
    logic [SW:0] rr2;
    rr2 = {1'b0, sq_r_r};
    if (s2_rr_r) hit3 = s2_rrhit_r;
    else if (s2_cc_r) hit3 = d00 <= rr2;
    else hit3 = (d00 <= rr2) || (d01 <= rr2) || (d10 <= rr2) || (d11 <= rr2) ||
                s2_box_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0;
    end else if (!stall) begin
      s1_v_r <= in_valid; s2_v_r <= s1_v_r; s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_r <= s1_nxt;
      s2_key_r  <= s1_r.key;
      s2_pair_r <= s1_r.pair;
      s2_rr_r   <= s1_r.rr;
      s2_cc_r   <= s1_r.cc;
      s2_rrhit_r <= ((s1_r.dx < 0 ? -s1_r.dx : s1_r.dx) <= s1_r.rad) &&
                    ((s1_r.dy < 0 ? -s1_r.dy : s1_r.dy) <= s1_r.hw);
      s2_box_r <= (s1_r.dx >= -s1_r.rad) && (s1_r.dx2 <= s1_r.dbx) &&
                  (s1_r.dy >= -s1_r.rad) && (s1_r.dy2 <= s1_r.dby);
      sq_dx_r  <= sq(s1_r.dx);
      sq_dy_r  <= sq(s1_r.dy);
      sq_ddx_r <= sq(s1_r.ddx);
      sq_ddy_r <= sq(s1_r.ddy);
      sq_r_r   <= sq(s1_r.rad);
      s3_key_r  <= s2_key_r;
      s3_pair_r <= s2_pair_r;
      s3_hit_r  <= hit3 && s2_pair_r;
    end
  end

  // queue
  logic push, pop;
  assign push = s3_v_r && !stall;
  assign pop  = q_valid && q_ready;
  assign q_valid = cnt_r != 2'd0;
  assign {q_key, q_pair, q_hit} = qm_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk) begin
    if (push) qm_r[wp_r] <= {s3_key_r, s3_pair_r, s3_hit_r};
  end

  q_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_ready) |-> !push) else $error("push into full queue");
  hit_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    s3_hit_r && s3_v_r |-> s3_pair_r) else $error("hit on invalid pair");
endmodule

// ===== design/cpct_back.sv =====
// Back part: reads the per-pair touching table with a registered read,
// forms the event, writes the table and holds the result register.
// Depends on cpct_pkg.
module cpct_back #(
  parameter int MAX_COLLIDERS = cpct_pkg::MaxCollidersDef,
  parameter int KeyW = 2 * cpct_pkg::IdW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [KeyW-1:0]   q_key,
  input  logic              q_pair,
  input  logic              q_hit,
  output logic              out_valid,
  input  logic              out_ready,
  output cpct_pkg::result_t out_data
);
  localparam int Depth = 1 << KeyW;
  logic             touch_mem [Depth];
  logic             clr_r;
  logic [KeyW-1:0]  clr_addr_r;
  logic             a_v_r, a_pair_r, a_hit_r, rd_r, fwd_v_r, fwd_d_r;
  logic [KeyW-1:0]  a_key_r;
  logic             was, now;
  cpct_pkg::event_t ev;
  logic             take, retire, a_ready, wr_en;

  assign retire  = a_v_r && (!out_valid || out_ready);
  assign a_ready = !a_v_r || retire;
  assign q_ready = !clr_r && a_ready;
  assign take    = q_valid && q_ready;
  // a repeat of the pair being written this edge takes the new bit
  assign was     = fwd_v_r ? fwd_d_r : rd_r;
  assign now     = a_pair_r && a_hit_r;
  assign wr_en   = retire && a_pair_r;

  always_comb begin
    ev = cpct_pkg::EV_NONE;
    if (a_pair_r) begin
      if (a_hit_r) ev = was ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
      else if (was) ev = cpct_pkg::EV_EXIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1; clr_addr_r <= '0;
      a_v_r <= 1'b0; fwd_v_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) clr_r <= 1'b0;
      end
      if (take) begin
        a_v_r <= 1'b1;
        fwd_v_r <= wr_en && (a_key_r == q_key);
      end else if (retire) begin
        a_v_r <= 1'b0;
      end
      if (retire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_key_r  <= q_key;
      a_pair_r <= q_pair;
      a_hit_r  <= q_hit;
      rd_r     <= touch_mem[q_key];
      fwd_d_r  <= now;
    end
    if (retire) begin
      out_data.contact_event <= ev;
      out_data.overlapping   <= now;
    end
  end

  // clear pass after reset, then one table write per retired valid pair
  always_ff @(posedge clk) begin
    if (clr_r) touch_mem[clr_addr_r] <= 1'b0;
    else if (wr_en) touch_mem[a_key_r] <= now;
  end

  logic unused_mc;
  assign unused_mc = (MAX_COLLIDERS > 0);

  no_take_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !q_ready) else $error("transfer during table clear");
  stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !retire |=> a_v_r && $stable(a_key_r))
    else $error("table stage lost its pair");
  no_event_bad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && !a_pair_r |-> ev == cpct_pkg::EV_NONE)
    else $error("event on invalid pair");
  hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
endmodule

// ===== design/collider_pair_contact_tracker.sv =====
// Top level of the collider pair contact tracker: front test pipe, queue and
// back table stage. Depends on cpct_pkg, cpct_if, cpct_front, cpct_back.
//  channel | dir | payload               | handshake
//  in_     | in  | cpct_pkg::item_t      | valid/ready
//  out_    | out | cpct_pkg::result_t    | valid/ready
// One pair per cycle sustained while the output is ready; after its input
// transfer a result passes 3 test stages, queue, table read and result reg.
// The squared-distance multipliers in stage 2 set the clock; a repeated pair
// right behind its twin takes the forwarded touching bit, so no bubble.
// After reset (rst_n low, synchronous) the back stage clears the 4096-entry
// touching table one entry per cycle and reads no queue entry until done.
// A full queue with a stalled output holds the front pipe.
module collider_pair_contact_tracker #(
  parameter int MAX_COLLIDERS = cpct_pkg::MaxCollidersDef
) (
  input logic clk,
  input logic rst_n,
  cpct_in_if.sink    in_ch,
  cpct_out_if.source out_ch
);
  localparam int KeyW = 2 * cpct_pkg::IdW;
  logic            q_valid, q_ready, q_pair, q_hit;
  logic [KeyW-1:0] q_key;

  cpct_front #(.MAX_COLLIDERS(MAX_COLLIDERS), .KeyW(KeyW)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_item(in_ch.data), .q_valid, .q_ready, .q_key, .q_pair, .q_hit);

  cpct_back #(.MAX_COLLIDERS(MAX_COLLIDERS), .KeyW(KeyW)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_key, .q_pair, .q_hit,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule
